// ===== rtl/core/mgrtd_pkg.sv =====
// Shared types and constants for the masked gray/RGB texel decoder.
package mgrtd_pkg;

    // Width of one stream byte and of one color channel.
    localparam int unsigned BYTE_W    = 8;
    // Width of the side exponent register.
    localparam int unsigned SIDE_W    = 4;
    // Smallest side exponent; smaller values act as this one.
    localparam logic [SIDE_W-1:0] SIDE_LOG2_MIN   = 4'd3;
    localparam logic [SIDE_W-1:0] SIDE_LOG2_RESET = 4'd3;
    // Texels covered by one mask byte (log2).
    localparam int unsigned GROUP_LOG2 = 3;

    // Register indexes of the configuration port.
    localparam int unsigned REG_SIDE_LOG2 = 0;

    // Byte phase within a texel group, one-hot coded.
    typedef enum logic [3:0] {
        PH_MASK  = 4'b0001,
        PH_FIRST = 4'b0010,
        PH_GREEN = 4'b0100,
        PH_BLUE  = 4'b1000
    } phase_t;

    // One decoded texel.
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              was_gray;
        logic              last_texel;
    } texel_t;

endpackage

// ===== rtl/core/mgrtd_cfg.sv =====
// APB register holding the side exponent of the lightmap.
module mgrtd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [mgrtd_pkg::SIDE_W-1:0] side_log2
);
    import mgrtd_pkg::*;

    logic [SIDE_W-1:0] side_log2_reg;
    logic              wr_en;
    logic              addr_hit;

    // Only the word at byte address zero holds a register.
    assign addr_hit = (paddr == 2'(REG_SIDE_LOG2 * 4));
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready && addr_hit;

    // Write at the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log2_reg <= SIDE_LOG2_RESET;
        end
        else if (wr_en)
        begin
            side_log2_reg <= pwdata[SIDE_W-1:0];
        end
    end

    // Read back the register; other addresses read as zero.
    assign prdata    = addr_hit ? {{(32-SIDE_W){1'b0}}, side_log2_reg} : 32'd0;
    assign side_log2 = side_log2_reg;

endmodule

// ===== rtl/core/mgrtd_decode.sv =====
// Byte phase, mask and position tracking; forms one texel per completed pixel.
module mgrtd_decode #(
    parameter int unsigned MAX_SIDE_LOG2 = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [mgrtd_pkg::BYTE_W-1:0] in_byte,
    input  logic [mgrtd_pkg::SIDE_W-1:0] side_log2,
    output logic                         res_valid,
    output mgrtd_pkg::texel_t            res
);
    import mgrtd_pkg::*;

    localparam int unsigned CNT_W = MAX_SIDE_LOG2;
    localparam logic [SIDE_W-1:0] SIDE_LOG2_MAX = SIDE_W'(MAX_SIDE_LOG2);

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  mask_reg, mask_next;
    logic [BYTE_W-1:0]  held_red_reg, held_red_next;
    logic [BYTE_W-1:0]  held_green_reg, held_green_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;

    logic [SIDE_W-1:0]  side_e;
    logic [CNT_W:0]     side_len;
    logic [CNT_W:0]     col_inc;
    logic [CNT_W:0]     row_inc;
    logic               row_end;
    logic               last;
    logic               emit;

    // Clamp the exponent and form the side length.
    always_comb
    begin
        priority if (side_log2 < SIDE_LOG2_MIN)
            side_e = SIDE_LOG2_MIN;
        else if (side_log2 > SIDE_LOG2_MAX)
            side_e = SIDE_LOG2_MAX;
        else
            side_e = side_log2;
    end

    assign side_len = (CNT_W+1)'(1) << side_e;
    assign col_inc  = {1'b0, col_reg} + (CNT_W+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (CNT_W+1)'(1);
    assign row_end  = (col_inc >= side_len);
    assign last     = row_end && (row_inc >= side_len);

    // Next state and result for the byte at the input.
    always_comb
    begin
        phase_next      = phase_reg;
        mask_next       = mask_reg;
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        emit            = 1'b0;
        res.red         = in_byte;
        res.green       = in_byte;
        res.blue        = in_byte;
        res.was_gray    = 1'b1;
        res.last_texel  = last;

        unique case (phase_reg)
            PH_MASK:
            begin
                mask_next  = in_byte;
                phase_next = PH_FIRST;
            end
            PH_FIRST:
            begin
                if (mask_reg[BYTE_W-1])
                begin
                    held_red_next = in_byte;
                    phase_next    = PH_GREEN;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_GREEN:
            begin
                held_green_next = in_byte;
                phase_next      = PH_BLUE;
            end
            PH_BLUE:
            begin
                emit         = 1'b1;
                res.red      = held_red_reg;
                res.green    = held_green_reg;
                res.was_gray = 1'b0;
            end
            default:
            begin
                phase_next = PH_MASK;
            end
        endcase

        // A finished texel advances the position and the mask.
        if (emit)
        begin
            mask_next = {mask_reg[BYTE_W-2:0], 1'b0};
            if (row_end)
            begin
                col_next = '0;
                row_next = last ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
            phase_next = (col_next[GROUP_LOG2-1:0] == '0) ? PH_MASK : PH_FIRST;
        end
    end

    assign res_valid = emit;

    // State advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MASK;
            mask_reg       <= '0;
            held_red_reg   <= '0;
            held_green_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            mask_reg       <= mask_next;
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
        end
    end

    // The final texel of the square sends both counters home.
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit && last |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters not cleared after final texel");

    // After a texel, a mask byte is expected exactly at a group boundary.
    a_group_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> ((col_reg[GROUP_LOG2-1:0] == '0) == (phase_reg == PH_MASK)))
        else $error("byte phase does not match group boundary");

    // Each texel consumes one mask bit.
    a_mask_shift: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> mask_reg == {$past(mask_reg[BYTE_W-2:0]), 1'b0})
        else $error("mask not shifted after texel");

endmodule

// ===== rtl/core/mgrtd_out_reg.sv =====
// Output register that holds one texel until the receiver takes it.
module mgrtd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mgrtd_pkg::texel_t res,
    input  logic              take,
    output logic              full,
    output mgrtd_pkg::texel_t texel
);
    import mgrtd_pkg::*;

    logic   full_reg, full_next;
    texel_t texel_reg;

    // Valid flag: set by a new texel, cleared when the held one is taken.
    always_comb
    begin
        priority if (load)
            full_next = 1'b1;
        else if (take)
            full_next = 1'b0;
        else
            full_next = full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            texel_reg <= res;
        end
    end

    assign full  = full_reg;
    assign texel = texel_reg;

endmodule

// ===== rtl/core/masked_gray_rgb_texel_decoder.sv =====
// Top level of the masked gray/RGB lightmap texel decoder.
//
// The input stream carries one raw byte per transaction on s_axis_tdata.
// Each group of eight texels in a row starts with a mask byte, read from
// the most significant bit; a set bit announces a red, green, blue triple
// and a clear bit one gray byte copied to all three channels.
// The output stream carries one texel per transaction: red, green and blue
// on m_axis_tdata, the gray flag on m_axis_tuser, and tlast on the final
// texel of the square. After that texel a new image of the same side begins.
// The side exponent is set through the APB port and should be written only
// while the block is idle; values outside 3 up to MAX_SIDE_LOG2 are clamped.
// A texel is presented in the cycle after the byte that completes it.
// Throughput: one byte per cycle, set by the single output register; the
// input is ready whenever that register is empty or being emptied.
// When the receiver stalls, the held texel stays put and s_axis_tready stays
// low until it is taken, even for bytes that would complete no texel.
// Reset clears the phase, the mask and both counters, empties the output
// register, and sets the side exponent to 3.
module masked_gray_rgb_texel_decoder #(
    parameter int unsigned MAX_SIDE_LOG2 = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_axis_tuser,   // [0] was_gray
    output logic        m_axis_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mgrtd_pkg::*;

    logic [SIDE_W-1:0] side_log2;
    logic              fire;
    logic              res_valid;
    texel_t            res;
    logic              out_full;
    logic              out_take;
    texel_t            out_texel;

    mgrtd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .side_log2 (side_log2)
    );

    // Accept a byte whenever the output register can take a result.
    assign out_take      = out_full && m_axis_tready;
    assign s_axis_tready = !out_full || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;

    mgrtd_decode #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_byte   (s_axis_tdata),
        .side_log2 (side_log2),
        .res_valid (res_valid),
        .res       (res)
    );

    mgrtd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire && res_valid),
        .res   (res),
        .take  (out_take),
        .full  (out_full),
        .texel (out_texel)
    );

    assign m_axis_tvalid = out_full;
    assign m_axis_tdata  = {out_texel.blue, out_texel.green, out_texel.red};
    assign m_axis_tuser  = out_texel.was_gray;
    assign m_axis_tlast  = out_texel.last_texel;

endmodule
